[hw/rtl/randomized_set_table_top_assert.svh]
// assertion macros for the randomized set table
`ifndef RANDOMIZED_SET_TABLE_TOP_ASSERT_SVH
`define RANDOMIZED_SET_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RSET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define RSET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rset_pkg.sv]
package rset_pkg;

	localparam int CAPACITY  = 64;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int VAL_W     = 32;
	localparam int RND_W     = 16;
	localparam int MOD_CNT_W = $clog2(RND_W + 1);
	localparam int TYPE_W    = 2;
	localparam int ST_W      = 2;
	localparam int OUT_CNT_W = 7;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_PICK   = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0]       req_type;
		logic signed [VAL_W-1:0] value;
		logic [RND_W-1:0]        random_word;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] picked_value;
		logic [OUT_CNT_W-1:0]    element_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic            load;
		logic            search;
		logic            mod_step;
		logic            rd_last;
		logic            rd_rem;
		logic            wr_append;
		logic            wr_slot;
		logic            finish;
		logic            pick_sel;
		logic [ST_W-1:0] fin_status;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic search_done;
		logic hit;
		logic full;
		logic empty;
		logic mod_done;
	} dp_stat_t;

endpackage

[hw/rtl/rset_datapath.sv]
module rset_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  rset_pkg::req_t    req,
	input  rset_pkg::ctl_cmd_t cmd,
	output rset_pkg::dp_stat_t stat,
	output rset_pkg::result_t result,
	output logic              done
);
	import rset_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	req_t                 req_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 pend_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     slot_q;
	logic [CNT_W-1:0]     rem_q;
	logic [RND_W-1:0]     rnd_sh_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	result_t              result_q;
	logic                 done_q;

	logic             match;
	logic             issue;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [CNT_W-1:0] last_cnt;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   trial_sub;

	assign match    = pend_q && (rdata_q == req_q.value);
	assign issue    = cmd.search && !hit_q && !match && (idx_q < count_q);
	assign last_cnt = count_q - CNT_W'(1);

	// one read port: search scan, last entry, or picked slot
	always_comb begin
		rd_en   = issue | cmd.rd_last | cmd.rd_rem;
		rd_addr = rem_q[IDX_W-1:0];
		priority if (issue) begin
			rd_addr = idx_q[IDX_W-1:0];
		end else if (cmd.rd_last) begin
			rd_addr = last_cnt[IDX_W-1:0];
		end else begin
			rd_addr = rem_q[IDX_W-1:0];
		end
	end

	always_comb begin
		wr_en   = cmd.wr_append | cmd.wr_slot;
		wr_addr = cmd.wr_slot ? slot_q : count_q[IDX_W-1:0];
		wr_data = cmd.wr_slot ? rdata_q : req_q.value;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// restoring remainder step, one dividend bit per cycle
	assign trial     = {rem_q, rnd_sh_q[RND_W-1]};
	assign trial_sub = trial - {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			hit_q     <= 1'b0;
			mod_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				idx_q     <= '0;
				pend_q    <= 1'b0;
				hit_q     <= 1'b0;
				mod_cnt_q <= '0;
			end
			if (cmd.search) begin
				if (match) begin
					hit_q <= 1'b1;
				end
				pend_q <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
			end
			if (cmd.wr_append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.wr_slot) begin
				count_q <= last_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req;
			rem_q    <= '0;
			rnd_sh_q <= req.random_word;
		end
		if (cmd.search && match) begin
			slot_q <= pend_idx_q;
		end
		if (issue) begin
			pend_idx_q <= idx_q[IDX_W-1:0];
		end
		if (cmd.mod_step) begin
			rem_q    <= (trial >= {1'b0, count_q}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			rnd_sh_q <= rnd_sh_q << 1;
		end
		if (cmd.finish) begin
			result_q.status        <= cmd.fin_status;
			result_q.picked_value  <= cmd.pick_sel ? rdata_q : '0;
			result_q.element_count <= OUT_CNT_W'(count_q);
		end
	end

	always_comb begin
		stat.search_done = hit_q || (!pend_q && (idx_q >= count_q));
		stat.hit         = hit_q;
		stat.full        = (count_q == CNT_W'(CAPACITY));
		stat.empty       = (count_q == '0);
		stat.mod_done    = (mod_cnt_q == MOD_CNT_W'(RND_W));
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

[hw/rtl/rset_ctrl.sv]
module rset_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rset_pkg::TYPE_W-1:0] req_type,
	input  rset_pkg::dp_stat_t          stat,
	output rset_pkg::ctl_cmd_t          cmd,
	output logic                        busy
);
	import rset_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_RM_RD  = 3'd3;
	localparam logic [2:0] S_RM_WR  = 3'd4;
	localparam logic [2:0] S_MOD    = 3'd5;
	localparam logic [2:0] S_PK_RD  = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [TYPE_W-1:0] op_q, op_d;
	logic [ST_W-1:0]   fin_st_q, fin_st_d;
	logic              pick_q, pick_d;

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		fin_st_d = fin_st_q;
		pick_d   = pick_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					op_d     = req_type;
					fin_st_d = ST_OK;
					pick_d   = 1'b0;
					unique case (req_type)
						REQ_INSERT, REQ_REMOVE: state_d = S_SEARCH;
						REQ_PICK:               state_d = stat.empty ? S_FINISH : S_MOD;
						default:                state_d = S_FINISH;
					endcase
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.search_done) begin
					if (op_q == REQ_INSERT) begin
						priority if (stat.hit) begin
							fin_st_d = ST_MISS;
							state_d  = S_FINISH;
						end else if (stat.full) begin
							fin_st_d = ST_FULL;
							state_d  = S_FINISH;
						end else begin
							state_d = S_APPEND;
						end
					end else if (stat.hit) begin
						state_d = S_RM_RD;
					end else begin
						fin_st_d = ST_MISS;
						state_d  = S_FINISH;
					end
				end
			end
			S_APPEND: begin
				cmd.wr_append = 1'b1;
				state_d       = S_FINISH;
			end
			S_RM_RD: begin
				cmd.rd_last = 1'b1;
				state_d     = S_RM_WR;
			end
			S_RM_WR: begin
				cmd.wr_slot = 1'b1;
				state_d     = S_FINISH;
			end
			S_MOD: begin
				if (stat.mod_done) begin
					state_d = S_PK_RD;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_PK_RD: begin
				cmd.rd_rem = 1'b1;
				pick_d     = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish     = 1'b1;
				cmd.fin_status = fin_st_q;
				cmd.pick_sel   = pick_q;
				state_d        = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= REQ_INSERT;
			fin_st_q <= ST_OK;
			pick_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			op_q     <= op_d;
			fin_st_q <= fin_st_d;
			pick_q   <= pick_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[hw/rtl/randomized_set_table_top.sv]
// channel   signals              transfer when
// request   start, busy, req     start high and busy low at a rising edge
// result    done, result         done high (one cycle, cannot be held off)
//
// one request at a time: busy is high from the transfer edge until the strobe cycle begins;
// the receiver cannot stall, so a result never waits and a new request may transfer then
// insert and remove scan the store one entry per cycle, then close the scan; on success insert
// appends the value and remove reads the last entry and moves it into the matched slot
// get random: 16-step serial remainder by the count and one read; skipped when empty
// reset clears the count and control state, not the store; store entries are written before they are read
module randomized_set_table_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rset_pkg::req_t    req,
	output logic              done,
	output rset_pkg::result_t result
);
	import rset_pkg::*;

	// command and status between controller and datapath
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// sequencer: decides scan, append, move, remainder and result steps
	rset_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// element store, count, scan pointer, remainder unit and result register
	rset_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

`include "randomized_set_table_top_assert.svh"

	// result strobe comes only after the sequence is back to idle
	`RSET_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	// an accepted request always starts a sequence
	`RSET_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
	// never append to a full store
	`RSET_ASSERT_NOW(a_no_overfill, cmd.wr_append, !stat.full, "append into full store")
	// every finish step yields exactly one strobe
	`RSET_ASSERT_NEXT(a_finish_strobe, cmd.finish, done, "finish without result strobe")

endmodule
